// ----- sv/sfrc_pkg.sv -----
`default_nettype none
package sfrc_pkg;

	localparam int SEQ_W   = 31;
	localparam int LEN_W   = 16;
	localparam int PRES_W  = 11;
	localparam int CBYTE_W = 15;
	localparam int VERD_W  = 3;

	localparam logic [LEN_W-1:0] FRAG_PAYLOAD_BYTES      = 16'd1300;
	localparam logic [LEN_W:0]   REASSEMBLY_BUFFER_BYTES = 17'd32768;
	localparam logic [LEN_W-1:0] RECEIVE_CAPACITY_RESET  = 16'd32768;

	typedef logic [VERD_W-1:0] verdict_t;

	localparam verdict_t V_STALE         = 3'd0;
	localparam verdict_t V_GAP           = 3'd1;
	localparam verdict_t V_BAD_LENGTH    = 3'd2;
	localparam verdict_t V_PARTIAL       = 3'd3;
	localparam verdict_t V_OVERFLOW      = 3'd4;
	localparam verdict_t V_DELIVER_WHOLE = 3'd5;
	localparam verdict_t V_DELIVER_REASM = 3'd6;

	// one parsed header request
	typedef struct packed {
		logic [SEQ_W-1:0]        seq_number;
		logic                    is_fragment;
		logic signed [LEN_W-1:0] frag_offset;
		logic signed [LEN_W-1:0] frag_bytes;
		logic [PRES_W-1:0]       bytes_present;
	} hdr_t;

	// one result request
	typedef struct packed {
		verdict_t            verdict;
		logic [SEQ_W-1:0]    skipped_count;
		logic [LEN_W-1:0]    copy_offset;
		logic [CBYTE_W-1:0]  copy_bytes;
		logic [LEN_W-1:0]    message_bytes;
	} result_t;

endpackage
`default_nettype wire

// ----- sv/sfrc_core.sv -----
`default_nettype none
module sfrc_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           fire,
	input  wire sfrc_pkg::hdr_t                 hdr,
	input  wire logic [sfrc_pkg::LEN_W-1:0]     capacity,
	output sfrc_pkg::result_t                   res
);
	import sfrc_pkg::*;

	logic [SEQ_W-1:0] last_seq_q;
	logic [SEQ_W-1:0] asm_seq_q;
	logic [LEN_W-1:0] asm_bytes_q;

	logic [SEQ_W-1:0] last_seq_d;
	logic [SEQ_W-1:0] asm_seq_d;
	logic [LEN_W-1:0] asm_bytes_d;

	logic             stale;
	logic             new_seq;
	logic [LEN_W-1:0] eff_asm;
	logic             gap;
	logic             bad_len;
	logic [LEN_W:0]   sum17;
	logic [LEN_W-1:0] total;

	always_comb begin
		stale   = hdr.seq_number <= last_seq_q;
		new_seq = hdr.seq_number != asm_seq_q;
		eff_asm = new_seq ? '0 : asm_bytes_q;
		// offset is signed, assembled count is unsigned
		gap     = $signed({hdr.frag_offset[LEN_W-1], hdr.frag_offset})
		          != $signed({1'b0, eff_asm});
		sum17   = {1'b0, eff_asm} + {1'b0, hdr.frag_bytes};
		bad_len = hdr.frag_bytes[LEN_W-1]
		          || ({1'b0, hdr.frag_bytes[LEN_W-2:0]}
		              > {{(LEN_W-PRES_W){1'b0}}, hdr.bytes_present})
		          || (sum17 > REASSEMBLY_BUFFER_BYTES);
		total   = sum17[LEN_W-1:0];

		res         = '0;
		last_seq_d  = last_seq_q;
		asm_seq_d   = asm_seq_q;
		asm_bytes_d = asm_bytes_q;

		if (stale) begin
			res.verdict = V_STALE;
		end else begin
			res.skipped_count = hdr.seq_number - last_seq_q - {{(SEQ_W-1){1'b0}}, 1'b1};
			if (!hdr.is_fragment) begin
				res.verdict = V_DELIVER_WHOLE;
				last_seq_d  = hdr.seq_number;
			end else begin
				// a new sequence restarts assembly even if rejected below
				asm_seq_d   = hdr.seq_number;
				asm_bytes_d = eff_asm;
				if (gap) begin
					res.verdict = V_GAP;
				end else if (bad_len) begin
					res.verdict = V_BAD_LENGTH;
				end else begin
					res.copy_offset = eff_asm;
					res.copy_bytes  = hdr.frag_bytes[CBYTE_W-1:0];
					asm_bytes_d     = total;
					if (hdr.frag_bytes == FRAG_PAYLOAD_BYTES) begin
						res.verdict = V_PARTIAL;
					end else if (total > capacity) begin
						res.verdict = V_OVERFLOW;
					end else begin
						res.verdict       = V_DELIVER_REASM;
						res.message_bytes = total;
						asm_bytes_d       = '0;
						last_seq_d        = hdr.seq_number;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q  <= '0;
			asm_seq_q   <= '0;
			asm_bytes_q <= '0;
		end else if (fire) begin
			last_seq_q  <= last_seq_d;
			asm_seq_q   <= asm_seq_d;
			asm_bytes_q <= asm_bytes_d;
		end
	end

	a_deliver_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.verdict == V_DELIVER_REASM
		|=> asm_bytes_q == '0 && last_seq_q == $past(hdr.seq_number))
		else $error("reassembled delivery did not close the message");

	a_last_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> last_seq_q >= $past(last_seq_q))
		else $error("last accepted sequence went backward");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(last_seq_q) && $stable(asm_seq_q) && $stable(asm_bytes_q))
		else $error("state changed without a request");

	a_buffer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, asm_bytes_q} <= REASSEMBLY_BUFFER_BYTES)
		else $error("assembled length beyond buffer");

endmodule
`default_nettype wire

// ----- sv/sequenced_fragment_reassembly_control.sv -----
// requests pass the input register, then are decided into the result register
// throughput: one request per cycle; out_stall backs up straight into in_stall
// through the input and result registers, with no bubble while both drain
// reset: arst_n clears sequence state, assembly state and both valid flags;
// receive_capacity returns to 32768
`default_nettype none
module sequenced_fragment_reassembly_control (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_wr_en,
	input  wire logic [sfrc_pkg::LEN_W-1:0]          cfg_wr_data,
	// header requests
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [sfrc_pkg::SEQ_W-1:0]          seq_number,
	input  wire logic                                is_fragment,
	input  wire logic signed [sfrc_pkg::LEN_W-1:0]   frag_offset,
	input  wire logic signed [sfrc_pkg::LEN_W-1:0]   frag_bytes,
	input  wire logic [sfrc_pkg::PRES_W-1:0]         bytes_present,
	// result requests
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [sfrc_pkg::VERD_W-1:0]              verdict,
	output logic [sfrc_pkg::SEQ_W-1:0]               skipped_count,
	output logic [sfrc_pkg::LEN_W-1:0]               copy_offset,
	output logic [sfrc_pkg::CBYTE_W-1:0]             copy_bytes,
	output logic [sfrc_pkg::LEN_W-1:0]               message_bytes
);
	import sfrc_pkg::*;

	logic [LEN_W-1:0] capacity_q;

	// input register
	logic    valid_s1;
	hdr_t    hdr_s1;

	// result register
	logic    valid_s2;
	result_t res_s2;

	result_t res_c;
	logic    advance;
	logic    fire;
	logic    in_take;

	// result register frees when empty or being taken this edge
	assign advance  = !valid_s2 || !out_stall;
	// the header in s1 is decided and state updated as it moves to s2
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= RECEIVE_CAPACITY_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			hdr_s1.seq_number    <= seq_number;
			hdr_s1.is_fragment   <= is_fragment;
			hdr_s1.frag_offset   <= frag_offset;
			hdr_s1.frag_bytes    <= frag_bytes;
			hdr_s1.bytes_present <= bytes_present;
		end
	end

	// decision logic and sequence / assembly state
	sfrc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.hdr      (hdr_s1),
		.capacity (capacity_q),
		.res      (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid     = valid_s2;
	assign verdict       = res_s2.verdict;
	assign skipped_count = res_s2.skipped_count;
	assign copy_offset   = res_s2.copy_offset;
	assign copy_bytes    = res_s2.copy_bytes;
	assign message_bytes = res_s2.message_bytes;

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(res_s2))
		else $error("stalled result lost or changed");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(hdr_s1))
		else $error("held header lost");

	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("decided header produced no result");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
module testbench;
	import sfrc_pkg::*;

	// generous ceiling on the whole run, well above the slowest legal run
	localparam int unsigned CYCLE_LIMIT = 400000;
	// length of the one long receiver hold-off
	localparam int LONG_HOLD_CYCLES = 300;

	// predicts one result per header request and keeps the results still owed
	class reassembly_scoreboard;
		logic [LEN_W-1:0] capacity;
		logic [SEQ_W-1:0] last_seq;
		logic [SEQ_W-1:0] asm_seq;
		logic [LEN_W-1:0] asm_bytes;
		result_t          owed_q[$];
		int               mismatches;
		int               checked;
		int               verdict_count[0:7];

		function new();
			capacity   = RECEIVE_CAPACITY_RESET;
			last_seq   = '0;
			asm_seq    = '0;
			asm_bytes  = '0;
			mismatches = 0;
			checked    = 0;
			foreach (verdict_count[i]) verdict_count[i] = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function verdict_t note_request(hdr_t h);
			result_t e;
			int      off;
			int      len;
			int      pres;
			e    = '0;
			off  = int'($signed(h.frag_offset));
			len  = int'($signed(h.frag_bytes));
			pres = int'(h.bytes_present);
			if (h.seq_number <= last_seq) begin
				e.verdict = V_STALE;
			end else begin
				e.skipped_count = h.seq_number - last_seq - 1'b1;
				if (!h.is_fragment) begin
					e.verdict = V_DELIVER_WHOLE;
					last_seq  = h.seq_number;
				end else begin
					if (h.seq_number != asm_seq) begin
						asm_seq   = h.seq_number;
						asm_bytes = '0;
					end
					if (off != int'(asm_bytes)) begin
						e.verdict = V_GAP;
					end else if (len < 0 || len > pres ||
							int'(asm_bytes) + len > int'(REASSEMBLY_BUFFER_BYTES)) begin
						e.verdict = V_BAD_LENGTH;
					end else begin
						e.copy_offset = asm_bytes;
						e.copy_bytes  = len[CBYTE_W-1:0];
						asm_bytes     = asm_bytes + len[LEN_W-1:0];
						if (len == int'(FRAG_PAYLOAD_BYTES)) begin
							e.verdict = V_PARTIAL;
						end else if (asm_bytes > capacity) begin
							e.verdict = V_OVERFLOW;
						end else begin
							e.verdict       = V_DELIVER_REASM;
							e.message_bytes = asm_bytes;
							asm_bytes       = '0;
							last_seq        = h.seq_number;
						end
					end
				end
			end
			owed_q.push_back(e);
			verdict_count[e.verdict]++;
			return e.verdict;
		endfunction

		function void check_result(result_t got);
			result_t e;
			checked++;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: verdict %0d skipped %0d off %0d bytes %0d msg %0d",
						got.verdict, got.skipped_count, got.copy_offset, got.copy_bytes,
						got.message_bytes);
				return;
			end
			e = owed_q.pop_front();
			if (e !== got) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d mismatch", checked);
					$display("  expected verdict %0d skipped %0d off %0d bytes %0d msg %0d",
						e.verdict, e.skipped_count, e.copy_offset, e.copy_bytes,
						e.message_bytes);
					$display("  actual   verdict %0d skipped %0d off %0d bytes %0d msg %0d",
						got.verdict, got.skipped_count, got.copy_offset, got.copy_bytes,
						got.message_bytes);
				end
			end
		endfunction
	endclass

	// every input known from time zero
	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    cfg_wr_en     = 1'b0;
	logic [LEN_W-1:0]        cfg_wr_data   = '0;
	logic                    in_valid      = 1'b0;
	logic                    in_stall;
	logic [SEQ_W-1:0]        seq_number    = '0;
	logic                    is_fragment   = 1'b0;
	logic signed [LEN_W-1:0] frag_offset   = '0;
	logic signed [LEN_W-1:0] frag_bytes    = '0;
	logic [PRES_W-1:0]       bytes_present = '0;
	logic                    out_valid;
	logic                    out_stall     = 1'b0;
	logic [VERD_W-1:0]       verdict;
	logic [SEQ_W-1:0]        skipped_count;
	logic [LEN_W-1:0]        copy_offset;
	logic [CBYTE_W-1:0]      copy_bytes;
	logic [LEN_W-1:0]        message_bytes;

	reassembly_scoreboard sb;
	result_t              got_result;

	int unsigned cycle_count   = 0;
	int          live_items    = 0;	// requests that were not stale
	int          cap_writes    = 0;
	int          burst_left    = 0;
	bit          gaps_on       = 1'b0;
	// receiver stall pattern state
	int          stall_mode    = 0;
	int          mode_left     = 0;
	int          hold_left     = 0;
	int          hold_requests = 0;
	int          holds_done    = 0;

	sequenced_fragment_reassembly_control uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.seq_number    (seq_number),
		.is_fragment   (is_fragment),
		.frag_offset   (frag_offset),
		.frag_bytes    (frag_bytes),
		.bytes_present (bytes_present),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.verdict       (verdict),
		.skipped_count (skipped_count),
		.copy_offset   (copy_offset),
		.copy_bytes    (copy_bytes),
		.message_bytes (message_bytes)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				sb.pending());
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: a new random stall mode is picked whenever the current one runs out; a long hold-off
	// is counted here once the stimulus asks for one
	always @(posedge clk) begin
		if (hold_requests != holds_done) begin
			holds_done = holds_done + 1;
			hold_left  = LONG_HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ((mode_left % 5) < 2);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// result monitor: a result request is taken when valid and not stalled
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_result.verdict       = verdict;
			got_result.skipped_count = skipped_count;
			got_result.copy_offset   = copy_offset;
			got_result.copy_bytes    = copy_bytes;
			got_result.message_bytes = message_bytes;
			sb.check_result(got_result);
		end
	end

	function automatic hdr_t mk(input logic [SEQ_W-1:0] seq, input bit frag, input int off,
			input int len, input int pres);
		hdr_t h;
		h.seq_number    = seq;
		h.is_fragment   = frag;
		h.frag_offset   = off[LEN_W-1:0];
		h.frag_bytes    = len[LEN_W-1:0];
		h.bytes_present = pres[PRES_W-1:0];
		return h;
	endfunction

	// next fresh sequence, mostly small steps, now and then a big jump
	function automatic logic [SEQ_W-1:0] next_seq();
		logic [SEQ_W-1:0] s;
		s = sb.last_seq + SEQ_W'($urandom_range(1, 3));
		if (sb.last_seq < 31'h7000_0000 && $urandom_range(0, 49) == 0)
			s = sb.last_seq + SEQ_W'($urandom_range(1, 1 << 24));
		if (s == sb.asm_seq && $urandom_range(0, 1) == 1)
			s = s + 1'b1;
		return s;
	endfunction

	task automatic idle(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// sender bursts when gaps_on is set: a random run of back-to-back requests, then a gap
	task automatic pace();
		if (gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				idle($urandom_range(1, 8));
				burst_left = $urandom_range(0, 15);
			end
		end
	endtask

	// offer one header request and hold it until the block takes it
	task automatic send_hdr(input hdr_t h);
		verdict_t v;
		seq_number    <= h.seq_number;
		is_fragment   <= h.is_fragment;
		frag_offset   <= h.frag_offset;
		frag_bytes    <= h.frag_bytes;
		bytes_present <= h.bytes_present;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		v = sb.note_request(h);
		if (v != V_STALE) live_items++;
		pace();
	endtask

	// stop offering and wait until every owed result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// capacity is only changed with the block empty
	task automatic write_capacity(input logic [LEN_W-1:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		sb.capacity = value;
		cap_writes++;
		cfg_wr_en <= 1'b0;
	endtask

	// one message: nparts full fragments then a closing one of another length;
	// optionally one fragment is broken, interrupted or repeated
	task automatic send_message(input logic [SEQ_W-1:0] seq, input int nparts,
			input bit corrupt);
		int bad_at;
		int off;
		int len;
		int pres;
		bad_at = corrupt ? int'($urandom_range(0, nparts)) : -1;
		off    = 0;
		for (int i = 0; i <= nparts; i++) begin
			if (i < nparts) begin
				len  = int'(FRAG_PAYLOAD_BYTES);
				pres = $urandom_range(int'(FRAG_PAYLOAD_BYTES), 2047);
			end else begin
				case ($urandom_range(0, 9))
					0: len = 0;
					1, 2: len = $urandom_range(int'(FRAG_PAYLOAD_BYTES) + 1, 2047);
					default: len = $urandom_range(1, int'(FRAG_PAYLOAD_BYTES) - 1);
				endcase
				pres = $urandom_range(len, 2047);
			end
			if (i == bad_at) begin
				case ($urandom_range(0, 4))
					0: send_hdr(mk(seq, 1'b1, off ^ (1 << $urandom_range(0, 15)), len, pres));
					1: send_hdr(mk(seq, 1'b1, off, -$urandom_range(1, 32768), pres));
					2: send_hdr(mk(seq, 1'b1, off, $urandom_range(pres + 1, 32767), pres));
					3: begin
						// whole datagram overtakes the message, the rest goes stale
						send_hdr(mk(seq + SEQ_W'(1 + $urandom_range(0, 3)), 1'b0, 0, 0, 0));
						send_hdr(mk(seq, 1'b1, off, len, pres));
					end
					default: begin
						// duplicated fragment
						send_hdr(mk(seq, 1'b1, off, len, pres));
						send_hdr(mk(seq, 1'b1, off, len, pres));
					end
				endcase
			end else begin
				send_hdr(mk(seq, 1'b1, off, len, pres));
			end
			off += len;
		end
	endtask

	task automatic run_random(input int target);
		int               start;
		int               pick;
		logic [SEQ_W-1:0] s;
		start = live_items;
		while (live_items - start < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				send_message(next_seq(), $urandom_range(0, 3), $urandom_range(0, 9) == 0);
			end else if (pick < 66) begin
				// long message near and past the reassembly buffer limit
				send_message(next_seq(), $urandom_range(24, 26), 1'b0);
			end else if (pick < 80) begin
				send_hdr(mk(next_seq(), 1'b0, $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 2047)));
			end else if (pick < 86) begin
				// stale or duplicate sequence
				send_hdr(mk(SEQ_W'($urandom_range(0, sb.last_seq)), 1'($urandom_range(0, 1)),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 2047)));
			end else begin
				// noise, sometimes aimed at the assembly in progress
				s = ($urandom_range(0, 1) == 1) ? next_seq() : sb.asm_seq;
				send_hdr(mk(s, $urandom_range(0, 3) != 0,
					($urandom_range(0, 1) == 1) ? int'(sb.asm_bytes) : $urandom_range(0, 65535),
					($urandom_range(0, 1) == 1) ? $urandom_range(0, 2047) : $urandom_range(0, 65535),
					$urandom_range(0, 2047)));
			end
		end
	endtask

	initial begin
		logic [LEN_W-1:0] caps[6];
		sb = new();
		caps[0] = 16'hFFFF;
		caps[1] = 16'd1000;
		caps[2] = 16'd32768;
		caps[3] = LEN_W'($urandom_range(0, 65535));
		caps[4] = 16'd32767;
		caps[5] = 16'd4000;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset capacity first
		send_hdr(mk(31'd0, 1'b0, 0, 0, 0));               // stale at reset
		send_hdr(mk(31'd1, 1'b0, 0, 0, 0));               // whole datagram
		send_hdr(mk(31'd5, 1'b1, 0, 1300, 2047));         // new sequence, partial
		send_hdr(mk(31'd5, 1'b1, 1300, 32767, 2047));     // longer than present
		send_hdr(mk(31'd5, 1'b1, 100, 10, 2047));         // gap
		send_hdr(mk(31'd5, 1'b1, 1300, -1, 2047));        // negative length
		send_hdr(mk(31'd5, 1'b1, 1300, 2047, 2047));      // completes the message
		send_hdr(mk(31'd5, 1'b0, 0, 0, 0));               // duplicate
		send_hdr(mk(31'd3, 1'b1, 0, 10, 10));             // older sequence
		send_hdr(mk(31'd7, 1'b1, 7, 10, 10));             // new sequence rejected by gap
		send_hdr(mk(31'd7, 1'b1, 0, 500, 500));           // assembly was restarted
		send_hdr(mk(31'd9, 1'b1, -32768, 0, 0));          // most negative offset
		send_hdr(mk(31'd9, 1'b1, 0, -32768, 2047));       // most negative length
		send_hdr(mk(31'd9, 1'b1, 0, 0, 0));               // empty message
		send_hdr(mk(31'd10, 1'b1, 32767, 1, 2047));       // largest offset
		send_hdr(mk(31'd11, 1'b0, 32767, 32767, 2047));   // whole, fields ignored

		// capacity zero: anything but an empty message overflows
		write_capacity(16'd0);
		send_hdr(mk(31'd12, 1'b1, 0, 1300, 1300));
		send_hdr(mk(31'd12, 1'b1, 1300, 1, 1));           // overflow, copy reported
		send_hdr(mk(31'd12, 1'b1, 1301, 0, 0));           // overflow keeps the total
		send_hdr(mk(31'd13, 1'b1, 0, 0, 0));              // empty still delivers

		// buffer limit: a long message near it, then just past it, then exactly at it
		write_capacity(16'hFFFF);
		send_message(31'd20, 25, 1'b0);
		for (int i = 0; i < 25; i++) send_hdr(mk(31'd21, 1'b1, i * 1300, 1300, 1300));
		send_hdr(mk(31'd21, 1'b1, 32500, 269, 269));      // one byte too many
		send_hdr(mk(31'd21, 1'b1, 32500, 268, 268));      // fills the buffer

		// random phases, one capacity setting each
		for (int p = 0; p < 6; p++) begin
			write_capacity(caps[p]);
			gaps_on = (p % 3 != 0);
			if (p == 2) hold_requests++;
			if (p == 3 && sb.last_seq < 31'h4000_0000)
				send_hdr(mk(31'h4000_0000 + SEQ_W'($urandom_range(0, 1 << 20)), 1'b0, 0, 0, 0));
			run_random(200);
		end

		// top of the sequence space, after which everything is stale
		drain();
		gaps_on = 1'b0;
		send_hdr(mk(31'h7FFF_FFFF, 1'b1, 0, 1300, 2047));
		send_hdr(mk(31'h7FFF_FFFF, 1'b0, 0, 0, 0));
		send_hdr(mk(31'h7FFF_FFFF, 1'b1, 1300, 5, 5));
		send_hdr(mk(SEQ_W'($urandom_range(0, 31'h7FFF_FFFE)), 1'b0, 0, 0, 0));

		drain();
		repeat (8) @(posedge clk);

		$display("summary: %0d results checked over %0d capacity settings", sb.checked,
			cap_writes);
		$display("summary: stale %0d gap %0d badlen %0d partial %0d overflow %0d whole %0d reasm %0d",
			sb.verdict_count[V_STALE], sb.verdict_count[V_GAP],
			sb.verdict_count[V_BAD_LENGTH], sb.verdict_count[V_PARTIAL],
			sb.verdict_count[V_OVERFLOW], sb.verdict_count[V_DELIVER_WHOLE],
			sb.verdict_count[V_DELIVER_REASM]);
		if (sb.pending() != 0)
			$display("%0d results never arrived", sb.pending());
		if (sb.mismatches > 10)
			$display("%0d mismatches in total", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- sequenced_fragment_reassembly_control.f -----
sv/sfrc_pkg.sv
sv/sfrc_core.sv
sv/sequenced_fragment_reassembly_control.sv
verif/testbench.sv
